@@ sv/pitt_pkg.sv @@
// ----------------------------------------------------------------------------
// pitt_pkg
// Shared types, register codes and helpers for the point-in-tetrahedron test.
// ----------------------------------------------------------------------------
package pitt_pkg;

  // Fixed geometry of the problem.
  localparam int NUM_VERT    = 4;
  localparam int NUM_FACE    = 4;
  localparam int NUM_AXIS    = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_TDATA_W = 8;

  // Bit positions of the result fields in out_tdata.
  localparam int OUT_BIT_INSIDE = 0;
  localparam int OUT_BIT_BOX    = 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_A = 2'd0,
    REG_VERTEX_B = 2'd1,
    REG_VERTEX_C = 2'd2,
    REG_VERTEX_D = 2'd3
  } reg_idx_t;

  // Sign of a dot product: negative flag and nonzero flag.
  typedef struct packed {
    logic neg;
    logic nz;
  } dot_sign_t;

  // A zero on either side counts as the same side.
  function automatic logic same_side(dot_sign_t a, dot_sign_t b);
    return !a.nz || !b.nz || (a.neg == b.neg);
  endfunction

endpackage

@@ sv/pitt_face_prep.sv @@
// ----------------------------------------------------------------------------
// pitt_face_prep
// Derives the vertex-only quantities from the vertex registers: bounding box,
// face normals and the sign of each normal against the opposite vertex.
// Runs every cycle as a four-stage pipeline of its own.
// ----------------------------------------------------------------------------
module pitt_face_prep
  import pitt_pkg::*;
#(
  parameter int  COORD_WIDTH = 20,
  localparam int DW = COORD_WIDTH + 1,
  localparam int PW = 2 * DW,
  localparam int NW = PW + 1,
  localparam int TW = NW + DW,
  localparam int SW = TW + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [3*COORD_WIDTH-1:0]      vert     [NUM_VERT],
  output logic signed [COORD_WIDTH-1:0] box_lo   [NUM_AXIS],
  output logic signed [COORD_WIDTH-1:0] box_hi   [NUM_AXIS],
  output logic signed [NW-1:0]          nrm      [NUM_FACE][NUM_AXIS],
  output dot_sign_t                     s4_sign  [NUM_FACE]
);

  logic signed [COORD_WIDTH-1:0] crd [NUM_VERT][NUM_AXIS];
  logic signed [DW-1:0]          e1  [NUM_FACE][NUM_AXIS];
  logic signed [DW-1:0]          e2  [NUM_FACE][NUM_AXIS];
  logic signed [DW-1:0]          d4  [NUM_FACE][NUM_AXIS];
  logic signed [COORD_WIDTH-1:0] lo_nxt [NUM_AXIS];
  logic signed [COORD_WIDTH-1:0] hi_nxt [NUM_AXIS];

  logic signed [PW-1:0]          pr_r   [NUM_FACE][6];
  logic signed [DW-1:0]          d4_r   [NUM_FACE][NUM_AXIS];
  logic signed [DW-1:0]          d4b_r  [NUM_FACE][NUM_AXIS];
  logic signed [NW-1:0]          n_r    [NUM_FACE][NUM_AXIS];
  logic signed [TW-1:0]          t_r    [NUM_FACE][NUM_AXIS];
  logic signed [SW-1:0]          sum    [NUM_FACE];
  dot_sign_t                     s4_r   [NUM_FACE];
  logic signed [COORD_WIDTH-1:0] lo_r   [NUM_AXIS];
  logic signed [COORD_WIDTH-1:0] hi_r   [NUM_AXIS];

  // Unpack the vertex coordinates.
  always_comb begin
    for (int v = 0; v < NUM_VERT; v++) begin
      for (int a = 0; a < NUM_AXIS; a++) begin
        crd[v][a] = $signed(vert[v][a*COORD_WIDTH +: COORD_WIDTH]);
      end
    end
  end

  // Edge vectors of each face; face f is spanned by vertices f, f+1, f+2.
  for (genvar f = 0; f < NUM_FACE; f++) begin : g_edge
    localparam int V1 = f;
    localparam int V2 = (f + 1) % NUM_VERT;
    localparam int V3 = (f + 2) % NUM_VERT;
    localparam int V4 = (f + 3) % NUM_VERT;
    for (genvar a = 0; a < NUM_AXIS; a++) begin : g_axis
      assign e1[f][a] = DW'(crd[V2][a]) - DW'(crd[V1][a]);
      assign e2[f][a] = DW'(crd[V3][a]) - DW'(crd[V1][a]);
      assign d4[f][a] = DW'(crd[V4][a]) - DW'(crd[V1][a]);
    end
  end

  // Bounding box over the four vertices.
  always_comb begin
    for (int a = 0; a < NUM_AXIS; a++) begin
      lo_nxt[a] = crd[0][a];
      hi_nxt[a] = crd[0][a];
      for (int v = 1; v < NUM_VERT; v++) begin
        if (crd[v][a] < lo_nxt[a]) lo_nxt[a] = crd[v][a];
        if (crd[v][a] > hi_nxt[a]) hi_nxt[a] = crd[v][a];
      end
    end
  end

  // Dot product sums against the opposite vertex.
  always_comb begin
    for (int f = 0; f < NUM_FACE; f++) begin
      sum[f] = SW'(t_r[f][0]) + SW'(t_r[f][1]) + SW'(t_r[f][2]);
    end
  end

  // Pipeline: cross-product terms, normals, dot terms, signs.
  // Reset to zero matches the all-zero vertices after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int f = 0; f < NUM_FACE; f++) begin
        for (int k = 0; k < 6; k++) pr_r[f][k] <= '0;
        for (int a = 0; a < NUM_AXIS; a++) begin
          d4_r[f][a]  <= '0;
          d4b_r[f][a] <= '0;
          n_r[f][a]   <= '0;
          t_r[f][a]   <= '0;
        end
        s4_r[f] <= '0;
      end
      for (int a = 0; a < NUM_AXIS; a++) begin
        lo_r[a] <= '0;
        hi_r[a] <= '0;
      end
    end else begin
      for (int f = 0; f < NUM_FACE; f++) begin
        pr_r[f][0] <= PW'(e1[f][1]) * PW'(e2[f][2]);
        pr_r[f][1] <= PW'(e1[f][2]) * PW'(e2[f][1]);
        pr_r[f][2] <= PW'(e1[f][2]) * PW'(e2[f][0]);
        pr_r[f][3] <= PW'(e1[f][0]) * PW'(e2[f][2]);
        pr_r[f][4] <= PW'(e1[f][0]) * PW'(e2[f][1]);
        pr_r[f][5] <= PW'(e1[f][1]) * PW'(e2[f][0]);
        n_r[f][0]  <= NW'(pr_r[f][0]) - NW'(pr_r[f][1]);
        n_r[f][1]  <= NW'(pr_r[f][2]) - NW'(pr_r[f][3]);
        n_r[f][2]  <= NW'(pr_r[f][4]) - NW'(pr_r[f][5]);
        for (int a = 0; a < NUM_AXIS; a++) begin
          d4_r[f][a]  <= d4[f][a];
          d4b_r[f][a] <= d4_r[f][a];
          t_r[f][a]   <= TW'(n_r[f][a]) * TW'(d4b_r[f][a]);
        end
        s4_r[f].neg <= sum[f][SW-1];
        s4_r[f].nz  <= |sum[f];
      end
      for (int a = 0; a < NUM_AXIS; a++) begin
        lo_r[a] <= lo_nxt[a];
        hi_r[a] <= hi_nxt[a];
      end
    end
  end

  assign box_lo  = lo_r;
  assign box_hi  = hi_r;
  assign nrm     = n_r;
  assign s4_sign = s4_r;

endmodule

@@ sv/pitt_query_pipe.sv @@
// ----------------------------------------------------------------------------
// pitt_query_pipe
// Five-stage query pipeline: offsets from the face origins, box compare,
// dot-product terms, dot-product signs, and the result register. Each stage
// carries a valid bit and loads when it is empty or the stage after it can move.
// ----------------------------------------------------------------------------
module pitt_query_pipe
  import pitt_pkg::*;
#(
  parameter int  COORD_WIDTH = 20,
  localparam int DW = COORD_WIDTH + 1,
  localparam int NW = 2 * DW + 1,
  localparam int TW = NW + DW,
  localparam int SW = TW + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [3*COORD_WIDTH-1:0]      point,
  input  logic [3*COORD_WIDTH-1:0]      vert    [NUM_VERT],
  input  logic signed [COORD_WIDTH-1:0] box_lo  [NUM_AXIS],
  input  logic signed [COORD_WIDTH-1:0] box_hi  [NUM_AXIS],
  input  logic signed [NW-1:0]          nrm     [NUM_FACE][NUM_AXIS],
  input  dot_sign_t                     s4_sign [NUM_FACE],
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          inside_res,
  output logic                          in_box
);

  localparam int NSTG = 5;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;

  logic signed [COORD_WIDTH-1:0] p      [NUM_AXIS];
  logic signed [COORD_WIDTH-1:0] p_r    [NUM_AXIS];
  logic signed [DW-1:0]          dp1_r  [NUM_FACE][NUM_AXIS];
  logic signed [DW-1:0]          dp2_r  [NUM_FACE][NUM_AXIS];
  logic signed [TW-1:0]          t_r    [NUM_FACE][NUM_AXIS];
  logic signed [SW-1:0]          sum    [NUM_FACE];
  dot_sign_t                     sp_r   [NUM_FACE];
  logic                          box2_r, box3_r, box4_r;
  logic                          box_nxt;
  logic                          pass_nxt;
  logic                          inside_r, inbox_r;

  // Ready chain: a stage moves when it is empty or its successor moves.
  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int s = NSTG - 2; s >= 0; s--) begin
      rdy[s] = !vld_r[s] || rdy[s+1];
    end
  end

  assign in_ready = rdy[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int s = 1; s < NSTG; s++) begin
        if (rdy[s]) vld_r[s] <= vld_r[s-1];
      end
    end
  end

  // Query coordinates.
  always_comb begin
    for (int a = 0; a < NUM_AXIS; a++) begin
      p[a] = $signed(point[a*COORD_WIDTH +: COORD_WIDTH]);
    end
  end

  // Inclusive box compare.
  always_comb begin
    box_nxt = 1'b1;
    for (int a = 0; a < NUM_AXIS; a++) begin
      if (p_r[a] < box_lo[a] || p_r[a] > box_hi[a]) box_nxt = 1'b0;
    end
  end

  // Dot sums of each face normal with the point offset.
  always_comb begin
    for (int f = 0; f < NUM_FACE; f++) begin
      sum[f] = SW'(t_r[f][0]) + SW'(t_r[f][1]) + SW'(t_r[f][2]);
    end
  end

  // Final decision: in the box and on the inner side of every face.
  always_comb begin
    pass_nxt = box4_r;
    for (int f = 0; f < NUM_FACE; f++) begin
      if (!same_side(s4_sign[f], sp_r[f])) pass_nxt = 1'b0;
    end
  end

  // Stage 1: point and its offsets from each face origin.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int a = 0; a < NUM_AXIS; a++) begin
        p_r[a] <= p[a];
        for (int f = 0; f < NUM_FACE; f++) begin
          dp1_r[f][a] <= DW'(p[a])
                       - DW'($signed(vert[f][a*COORD_WIDTH +: COORD_WIDTH]));
        end
      end
    end
  end

  // Stage 2: box flag.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      box2_r <= box_nxt;
      dp2_r  <= dp1_r;
    end
  end

  // Stage 3: products of normal and offset.
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      box3_r <= box2_r;
      for (int f = 0; f < NUM_FACE; f++) begin
        for (int a = 0; a < NUM_AXIS; a++) begin
          t_r[f][a] <= TW'(nrm[f][a]) * TW'(dp2_r[f][a]);
        end
      end
    end
  end

  // Stage 4: sign of each dot product.
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      box4_r <= box3_r;
      for (int f = 0; f < NUM_FACE; f++) begin
        sp_r[f].neg <= sum[f][SW-1];
        sp_r[f].nz  <= |sum[f];
      end
    end
  end

  // Stage 5: result register.
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      inside_r <= pass_nxt;
      inbox_r  <= box4_r;
    end
  end

  assign out_valid  = vld_r[NSTG-1];
  assign inside_res = inside_r;
  assign in_box     = inbox_r;

endmodule

@@ sv/point_in_tetrahedron_test_unit.sv @@
// ----------------------------------------------------------------------------
// point_in_tetrahedron_test_unit
// Same-side point-in-tetrahedron test with an inclusive bounding-box check.
// ----------------------------------------------------------------------------
// Usage:
//   The four vertices are written through the cfg_ channel (cfg_index 0..3
//   selects vertex a..d; cfg_data holds x, y, z from the low bits up, each a
//   signed COORD_WIDTH-bit value). Write them while no query is in flight.
//   Query points enter on the in_ stream, one request per cycle at most.
//   Each request produces exactly one result on the out_ stream, in order.
// Throughput and depth:
//   The unit sustains one request per cycle unless in_tready drops for a
//   result stall or a vertex write.
//   The depth is set by the dot-product multipliers, which have a stage of
//   their own, followed by a stage for the wide sums.
//   A query accepted right after a vertex write sees the new vertices, since
//   the vertex-only terms settle in pitt_face_prep and reach every stage in time.
// Reset and stall:
//   rst_n (synchronous, active low) clears the pipeline and sets all vertices
//   to zero. When out_tready is low the result holds; earlier stages keep
//   filling until the pipe is full, and only then does in_tready drop.
// ----------------------------------------------------------------------------
module point_in_tetrahedron_test_unit
  import pitt_pkg::*;
#(
  parameter int  COORD_WIDTH = 20,
  localparam int VW = 3 * COORD_WIDTH,
  localparam int IW = ((VW + 7) / 8) * 8,
  localparam int NW = 2 * (COORD_WIDTH + 1) + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [VW-1:0]          cfg_data,
  // Query stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IW-1:0]          in_tdata,   // point_x, point_y, point_z, zero pad
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // inside_res, in_box, zero pad
);

  logic [VW-1:0]                 vertex_r [NUM_VERT];
  logic signed [COORD_WIDTH-1:0] box_lo   [NUM_AXIS];
  logic signed [COORD_WIDTH-1:0] box_hi   [NUM_AXIS];
  logic signed [NW-1:0]          nrm      [NUM_FACE][NUM_AXIS];
  dot_sign_t                     s4_sign  [NUM_FACE];
  logic                          pipe_ready;
  logic                          inside_res;
  logic                          in_box;
  reg_idx_t                      cfg_sel;

  assign cfg_ready = 1'b1;
  assign cfg_sel   = reg_idx_t'(cfg_index);

  // Vertex registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < NUM_VERT; v++) vertex_r[v] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_sel)
        REG_VERTEX_A: vertex_r[0] <= cfg_data;
        REG_VERTEX_B: vertex_r[1] <= cfg_data;
        REG_VERTEX_C: vertex_r[2] <= cfg_data;
        REG_VERTEX_D: vertex_r[3] <= cfg_data;
      endcase
    end
  end

  // A query never enters in the same cycle as a vertex write.
  assign in_tready = pipe_ready && !cfg_valid;

  pitt_face_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .vert    (vertex_r),
    .box_lo  (box_lo),
    .box_hi  (box_hi),
    .nrm     (nrm),
    .s4_sign (s4_sign)
  );

  pitt_query_pipe #(.COORD_WIDTH(COORD_WIDTH)) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid && !cfg_valid),
    .in_ready   (pipe_ready),
    .point      (in_tdata[VW-1:0]),
    .vert       (vertex_r),
    .box_lo     (box_lo),
    .box_hi     (box_hi),
    .nrm        (nrm),
    .s4_sign    (s4_sign),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .inside_res (inside_res),
    .in_box     (in_box)
  );

  // Result packing.
  always_comb begin
    out_tdata                 = '0;
    out_tdata[OUT_BIT_INSIDE] = inside_res;
    out_tdata[OUT_BIT_BOX]    = in_box;
  end

endmodule

@@ sv/pitt_checker.sv @@
// ----------------------------------------------------------------------------
// pitt_checker
// Port-level checks for the point-in-tetrahedron unit, bound to the top level.
// ----------------------------------------------------------------------------
module pitt_checker
  import pitt_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   cfg_valid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Inside implies in the box.
  a_inside_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[OUT_BIT_INSIDE] || out_tdata[OUT_BIT_BOX])
    else $error("inside flag without box flag");

  // No query is taken in the cycle of a vertex write.
  a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> !in_tready)
    else $error("query accepted during vertex write");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind point_in_tetrahedron_test_unit pitt_checker u_chk (.*);

@@ verif/point_in_tetrahedron_test_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_in_tetrahedron_test_unit_tb
// Self-checking bench for the same-side point-in-tetrahedron test.
// The bench loads tetrahedra through the configuration channel and streams
// query points. An exact 128-bit integer predictor computes the bounding-box
// and same-side verdicts for every accepted request. Directed cases cover the
// reset vertices, boundary points, range extremes, both orientations and a
// flat tetrahedron. Random phases use wide, local and flat tetrahedra, with
// random idling on both sides, one calm stretch and one long output stall.
// ----------------------------------------------------------------------------
module point_in_tetrahedron_test_unit_tb;
  import pitt_pkg::*;

  localparam int CW        = 20;
  localparam int VW        = 3 * CW;
  localparam int IW        = ((VW + 7) / 8) * 8;
  localparam int CMIN      = -(1 << (CW - 1));
  localparam int CMAX      = (1 << (CW - 1)) - 1;
  localparam int LATENCY   = 4;
  localparam int MAX_CYCLE = 200000;

  localparam reg_idx_t VERTEX_REGS[NUM_VERT] = '{REG_VERTEX_A, REG_VERTEX_B,
                                                 REG_VERTEX_C, REG_VERTEX_D};

  typedef logic signed [127:0] big_t;
  typedef big_t vec3_t [NUM_AXIS];

  typedef struct {
    logic inside_res;
    logic in_box;
  } verdict_t;

  typedef enum int {SHAPE_WIDE, SHAPE_LOCAL, SHAPE_FLAT} shape_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = REG_VERTEX_A;
  logic [VW-1:0]          cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IW-1:0]          in_tdata   = '0;   // point_x, point_y, point_z, zero pad
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // inside_res, in_box, zero pad

  // Vertex registers as the bench believes them, and their coordinates.
  logic [VW-1:0] vertex_regs[NUM_VERT];
  int            corner[NUM_VERT][NUM_AXIS];

  verdict_t verdict_q[$];
  int       err_count     = 0;
  int       cycle_count   = 0;
  bit       calm_mode     = 1'b0;
  int       hold_request  = 0;
  int       hold_left     = 0;

  point_in_tetrahedron_test_unit #(.COORD_WIDTH(CW)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("point_in_tetrahedron_test_unit test failed");
      $finish;
    end
  end

  // Sign test of one face: a zero dot product on either side passes.
  function automatic bit face_ok(vec3_t v1, vec3_t v2, vec3_t v3, vec3_t v4,
                                 vec3_t p);
    big_t e1[NUM_AXIS], e2[NUM_AXIS], d4[NUM_AXIS], dp[NUM_AXIS], n[NUM_AXIS];
    big_t s4, sp;
    for (int k = 0; k < NUM_AXIS; k++) begin
      e1[k] = v2[k] - v1[k];
      e2[k] = v3[k] - v1[k];
      d4[k] = v4[k] - v1[k];
      dp[k] = p[k] - v1[k];
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    s4 = n[0] * d4[0] + n[1] * d4[1] + n[2] * d4[2];
    sp = n[0] * dp[0] + n[1] * dp[1] + n[2] * dp[2];
    return (s4 == 0) || (sp == 0) || ((s4 < 0) == (sp < 0));
  endfunction

  // Box and same-side verdict for one query against the current vertices.
  function automatic verdict_t predict_verdict(logic [CW-1:0] px, logic [CW-1:0] py,
                                               logic [CW-1:0] pz);
    vec3_t    v[NUM_VERT];
    vec3_t    p;
    big_t     lo, hi;
    verdict_t r;
    p[0] = big_t'($signed(px));
    p[1] = big_t'($signed(py));
    p[2] = big_t'($signed(pz));
    for (int i = 0; i < NUM_VERT; i++)
      for (int k = 0; k < NUM_AXIS; k++)
        v[i][k] = big_t'($signed(vertex_regs[i][k*CW +: CW]));
    r.in_box = 1'b1;
    for (int k = 0; k < NUM_AXIS; k++) begin
      lo = v[0][k];
      hi = v[0][k];
      for (int i = 1; i < NUM_VERT; i++) begin
        if (v[i][k] < lo) lo = v[i][k];
        if (v[i][k] > hi) hi = v[i][k];
      end
      if (p[k] < lo || p[k] > hi) r.in_box = 1'b0;
    end
    r.inside_res = r.in_box &&
                   face_ok(v[0], v[1], v[2], v[3], p) &&
                   face_ok(v[1], v[2], v[3], v[0], p) &&
                   face_ok(v[2], v[3], v[0], v[1], p) &&
                   face_ok(v[3], v[0], v[1], v[2], p);
    return r;
  endfunction

  function automatic int rand_span(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Result checking and output-side flow control.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result inside_res=%0b in_box=%0b", $time,
                 out_tdata[OUT_BIT_INSIDE], out_tdata[OUT_BIT_BOX]);
        err_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata[OUT_BIT_INSIDE] !== want.inside_res) begin
          $display("%0t: inside_res expected %0b actual %0b", $time,
                   want.inside_res, out_tdata[OUT_BIT_INSIDE]);
          err_count++;
        end
        if (out_tdata[OUT_BIT_BOX] !== want.in_box) begin
          $display("%0t: in_box expected %0b actual %0b", $time,
                   want.in_box, out_tdata[OUT_BIT_BOX]);
          err_count++;
        end
      end
    end
    // A pending hold-off takes priority over random idling.
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm_mode || ($urandom_range(99) >= 14);
    end
  end

  // Offer one query point and record its verdict once accepted.
  task automatic send_point(input int x, input int y, input int z);
    logic [CW-1:0] px, py, pz;
    px = x[CW-1:0];
    py = y[CW-1:0];
    pz = z[CW-1:0];
    if (!calm_mode) begin
      while ($urandom_range(99) < 14) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IW - VW){1'b0}}, pz, py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    verdict_q = {verdict_q, predict_verdict(px, py, pz)};
  endtask

  // Stop offering and wait until every request has come back.
  task automatic settle_pipeline();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
  endtask

  // Write all four vertex registers from corner[] while the pipe is empty.
  task automatic write_tetra();
    logic [VW-1:0] packed_vertex;
    settle_pipeline();
    for (int i = 0; i < NUM_VERT; i++) begin
      packed_vertex = {corner[i][2][CW-1:0], corner[i][1][CW-1:0],
                       corner[i][0][CW-1:0]};
      cfg_valid <= 1'b1;
      cfg_index <= VERTEX_REGS[i];
      cfg_data  <= packed_vertex;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      vertex_regs[i] = packed_vertex;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_corner(input int i, input int x, input int y, input int z);
    corner[i][0] = x;
    corner[i][1] = y;
    corner[i][2] = z;
  endtask

  // Choose a query: mostly inside or near the tetrahedron, some anywhere.
  task automatic pick_point(output int pt[NUM_AXIS]);
    int w[NUM_VERT];
    int wsum, acc, lo, hi, sel, vi;
    sel  = $urandom_range(99);
    vi   = $urandom_range(NUM_VERT - 1);
    wsum = 0;
    for (int i = 0; i < NUM_VERT; i++) begin
      w[i] = $urandom_range(15);
      wsum += w[i];
    end
    if (wsum == 0) begin
      w[0] = 1;
      wsum = 1;
    end
    for (int k = 0; k < NUM_AXIS; k++) begin
      lo  = corner[0][k];
      hi  = corner[0][k];
      acc = 0;
      for (int i = 0; i < NUM_VERT; i++) begin
        if (corner[i][k] < lo) lo = corner[i][k];
        if (corner[i][k] > hi) hi = corner[i][k];
        acc += w[i] * corner[i][k];
      end
      if (sel < 40)      pt[k] = acc / wsum;
      else if (sel < 75) pt[k] = rand_span(lo, hi);
      else if (sel < 90) pt[k] = rand_span(CMIN, CMAX);
      else               pt[k] = corner[vi][k] + rand_span(-2, 2);
    end
  endtask

  task automatic load_random_tetra(input shape_t shape);
    int spread;
    int center[NUM_AXIS];
    spread = 1 << $urandom_range(18);
    for (int k = 0; k < NUM_AXIS; k++)
      center[k] = rand_span(CMIN + spread, CMAX - spread);
    for (int i = 0; i < NUM_VERT; i++) begin
      for (int k = 0; k < NUM_AXIS; k++) begin
        if (shape == SHAPE_WIDE) corner[i][k] = rand_span(CMIN, CMAX);
        else corner[i][k] = rand_span(center[k] - spread, center[k] + spread);
      end
      // A flat tetrahedron keeps all four vertices in one z plane.
      if (shape == SHAPE_FLAT) corner[i][2] = center[2];
    end
    write_tetra();
  endtask

  task automatic send_random_points(input int count);
    int pt[NUM_AXIS];
    for (int n = 0; n < count; n++) begin
      pick_point(pt);
      send_point(pt[0], pt[1], pt[2]);
    end
  endtask

  // After reset every vertex is the origin: only the origin is in the box.
  task automatic test_reset_vertices();
    for (int i = 0; i < NUM_VERT; i++) begin
      vertex_regs[i] = '0;
      set_corner(i, 0, 0, 0);
    end
    send_point(0, 0, 0);
    send_point(1, 0, 0);
    send_point(CMIN, CMIN, CMIN);
    send_point(CMAX, CMAX, CMAX);
  endtask

  // Right-angle corner tetrahedron: interior, vertex, face and box corner.
  task automatic test_unit_corner();
    set_corner(0, 0, 0, 0);
    set_corner(1, 1000, 0, 0);
    set_corner(2, 0, 1000, 0);
    set_corner(3, 0, 0, 1000);
    write_tetra();
    send_point(100, 100, 100);
    send_point(0, 0, 0);
    send_point(500, 500, 0);
    send_point(334, 333, 333);
    send_point(900, 900, 900);
    send_point(-1, 0, 0);
  endtask

  // Vertices at the coordinate extremes, in both orientations.
  task automatic test_range_extremes();
    set_corner(0, CMIN, CMIN, CMIN);
    set_corner(1, CMAX, CMIN, CMIN);
    set_corner(2, CMIN, CMAX, CMIN);
    set_corner(3, CMIN, CMIN, CMAX);
    write_tetra();
    send_point(CMIN, CMIN, CMIN);
    send_point(CMAX, CMAX, CMAX);
    send_point(-1, -1, -1);
    send_point(-262144, -262144, -262144);
    set_corner(1, CMIN, CMAX, CMIN);
    set_corner(2, CMAX, CMIN, CMIN);
    write_tetra();
    send_point(-262144, -262144, -262144);
    send_point(0, 0, 0);
  endtask

  // Coplanar vertices: every point of the box lies on the plane.
  task automatic test_flat_tetra();
    set_corner(0, 0, 0, 5);
    set_corner(1, 100, 0, 5);
    set_corner(2, 0, 100, 5);
    set_corner(3, 100, 100, 5);
    write_tetra();
    send_point(50, 50, 5);
    send_point(100, 100, 5);
    send_point(150, 0, 5);
    send_point(50, 50, 6);
  endtask

  task automatic test_random_tetra(input shape_t shape, input int count);
    load_random_tetra(shape);
    send_random_points(count);
  endtask

  // No idling on either side for a long stretch.
  task automatic test_calm_stream();
    load_random_tetra(SHAPE_LOCAL);
    calm_mode = 1'b1;
    send_random_points(60);
    settle_pipeline();
    calm_mode = 1'b0;
  endtask

  // The receiver stalls long enough for the pipe to fill and block input.
  task automatic test_backpressure();
    load_random_tetra(SHAPE_LOCAL);
    hold_request = 300;
    send_random_points(60);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_vertices();
    test_unit_corner();
    test_range_extremes();
    test_flat_tetra();
    test_random_tetra(SHAPE_LOCAL, 80);
    test_random_tetra(SHAPE_WIDE, 80);
    test_random_tetra(SHAPE_FLAT, 80);
    test_random_tetra(SHAPE_LOCAL, 80);
    test_calm_stream();
    test_backpressure();
    test_random_tetra(SHAPE_WIDE, 80);
    settle_pipeline();
    repeat (4 * LATENCY) @(posedge clk);
    if (err_count == 0) begin
      $display("point_in_tetrahedron_test_unit test passed");
    end else begin
      $display("point_in_tetrahedron_test_unit test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/pitt_pkg.sv
sv/pitt_face_prep.sv
sv/pitt_query_pipe.sv
sv/point_in_tetrahedron_test_unit.sv
sv/pitt_checker.sv
verif/point_in_tetrahedron_test_unit_tb.sv
